// ===== hw/rtl/box_blur_3x3_rgb_core_defines.svh =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core_defines.svh
// Assertion macros used by the blur core port checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH

// clocked property, off while reset is high
`define BB3_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// clocked property, also checked around reset
`define BB3_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ===== hw/rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants of the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int REG_W = 11;            // widest configuration register
   localparam int CH_W  = 8;             // one color channel
   localparam int COL_W = 10;            // sum of three channel values
   localparam int SUM_W = 12;            // sum of nine channel values

   localparam int FRAME_WIDTH_RST  = 800;
   localparam int FRAME_HEIGHT_RST = 600;
   localparam int MIN_WIDTH  = 3;
   localparam int MIN_HEIGHT = 2;

   // x / 9 == (x * 3641) >> 15 for every x up to 9 * 255
   localparam int DIV9_MUL   = 3641;
   localparam int DIV9_SHIFT = 15;
   localparam int MUL_W      = 12;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam int IDX_W = $bits(reg_index_type);

   typedef struct packed {
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
   } pixel_type;

   typedef struct packed {
      logic [COL_W-1:0] r;
      logic [COL_W-1:0] g;
      logic [COL_W-1:0] b;
   } col_sum_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } win_sum_type;

   typedef struct packed {
      logic [CH_W-1:0] in_red;
      logic [CH_W-1:0] in_green;
      logic [CH_W-1:0] in_blue;
      logic            flush;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic [CH_W-1:0] out_alpha;
      logic            end_of_frame;
   } rsp_type;

   // per-item control carried from the position logic into the window stage
   typedef struct packed {
      pixel_type pix;
      logic      top;     // drop the row above
      logic      bot;     // drop the row below
      logic      left;    // drop the column to the left
      logic      right;   // drop the column to the right
      logic      emit;
      logic      eof;
   } stage_ctl_type;

endpackage

// ===== hw/rtl/bb3_stream_if.sv =====
// ----------------------------------------------------------------------------
// bb3_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface bb3_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bb3_window.sv =====
// ----------------------------------------------------------------------------
// bb3_window
// Line store (two rows per entry), 3x3 window registers and row-masked
// column sums of the shifted window.
// ----------------------------------------------------------------------------
module bb3_window #(
   parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   input  logic                  step,
   input  logic [AW-1:0]         wr_addr,
   input  bb3_pkg::stage_ctl_type ctl,
   output bb3_pkg::col_sum_type  col_sum [3]
);

   localparam int PW = $bits(bb3_pkg::pixel_type);

   logic [2*PW-1:0]    mem [MAX_WIDTH];
   logic [2*PW-1:0]    rdata_ff;
   bb3_pkg::pixel_type upper;
   bb3_pkg::pixel_type lower;

   // [column: 0 oldest][row: 0 top]
   bb3_pkg::pixel_type win_ff [3][3];
   bb3_pkg::pixel_type win_in [3][3];

   assign upper = bb3_pkg::pixel_type'(rdata_ff[2*PW-1:PW]);
   assign lower = bb3_pkg::pixel_type'(rdata_ff[PW-1:0]);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (step) begin
         mem[wr_addr] <= {lower, ctl.pix};
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[0][r] = win_ff[1][r];
         win_in[1][r] = win_ff[2][r];
      end
      win_in[2][0] = upper;
      win_in[2][1] = lower;
      win_in[2][2] = ctl.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else if (step) begin
         win_ff <= win_in;
      end
   end

   // row masks apply to every column of the shifted window
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_sum[c].r = (ctl.top ? '0 : bb3_pkg::COL_W'(win_in[c][0].r))
                      + bb3_pkg::COL_W'(win_in[c][1].r)
                      + (ctl.bot ? '0 : bb3_pkg::COL_W'(win_in[c][2].r));
         col_sum[c].g = (ctl.top ? '0 : bb3_pkg::COL_W'(win_in[c][0].g))
                      + bb3_pkg::COL_W'(win_in[c][1].g)
                      + (ctl.bot ? '0 : bb3_pkg::COL_W'(win_in[c][2].g));
         col_sum[c].b = (ctl.top ? '0 : bb3_pkg::COL_W'(win_in[c][0].b))
                      + bb3_pkg::COL_W'(win_in[c][1].b)
                      + (ctl.bot ? '0 : bb3_pkg::COL_W'(win_in[c][2].b));
      end
   end

endmodule

// ===== hw/rtl/box_blur_3x3_rgb_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// 3x3 box blur over a raster RGB stream, sum / 9 with zero outside the frame.
// ----------------------------------------------------------------------------
//  channel     dir   handshake        payload
//  req_stream  in    valid / ready    in_red, in_green, in_blue, flush
//  rsp_stream  out   valid / ready    out_red/green/blue, out_alpha, end_of_frame
//  csr_*       in    csr_we           csr_index, csr_wdata (11 bits)
//
//  One beat per clock in and out while the output does not stall. A result
//  passes the window, column sum and window sum registers into the output
//  register; the line store read sets the first stage. The result of pixel
//  k comes with input beat k + W + 1. Reset clears counters, window and
//  valid flags; the line store is not cleared. Output backpressure holds the
//  output register and fills the pipeline bubbles before req_stream.ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bb3_stream_if.sink                 req_stream,
   bb3_stream_if.source               rsp_stream,
   input  logic                       csr_we,
   input  logic [bb3_pkg::IDX_W-1:0]  csr_index,
   input  logic [bb3_pkg::REG_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT) + 2;
   localparam int PW = bb3_pkg::MUL_W + bb3_pkg::SUM_W;

   function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
      int unsigned res;
      res = v;
      if (v < lo) res = lo;
      if (v > hi) res = hi;
      return res;
   endfunction

   localparam logic [WW-1:0] W_RST =
      WW'(sat(bb3_pkg::FRAME_WIDTH_RST, bb3_pkg::MIN_WIDTH, MAX_WIDTH));
   localparam logic [HW-1:0] H_RST =
      HW'(sat(bb3_pkg::FRAME_HEIGHT_RST, bb3_pkg::MIN_HEIGHT, MAX_HEIGHT));
   localparam logic [bb3_pkg::MUL_W-1:0] DIV9 = bb3_pkg::MUL_W'(bb3_pkg::DIV9_MUL);

   // effective frame size, saturated on write
   logic [WW-1:0] w_ff;
   logic [HW-1:0] h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= W_RST;
         h_ff <= H_RST;
      end else if (csr_we) begin
         case (bb3_pkg::reg_index_type'(csr_index))
            bb3_pkg::REG_FRAME_WIDTH: begin
               w_ff <= WW'(sat(32'(csr_wdata), bb3_pkg::MIN_WIDTH, MAX_WIDTH));
            end
            bb3_pkg::REG_FRAME_HEIGHT: begin
               h_ff <= HW'(sat(32'(csr_wdata), bb3_pkg::MIN_HEIGHT, MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   logic vb_ff, vc_ff, vd_ff, ov_ff;
   logic rdy_o, rdy_d, rdy_c, rdy_b;
   logic accept, step_b;

   assign rdy_o  = !ov_ff || rsp_stream.ready;
   assign rdy_d  = !vd_ff || rdy_o;
   assign rdy_c  = !vc_ff || rdy_d;
   assign rdy_b  = !vb_ff || rdy_c;
   assign accept = req_stream.valid && rdy_b;
   assign step_b = vb_ff && rdy_c;
   assign req_stream.ready = rdy_b;

   // ---------------- position counters ----------------
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [WW-1:0] ic_e, ic_n, oc_e, oc_n, w_m1;
   logic [RW-1:0] ir_e, or_e, h_e;
   bb3_pkg::stage_ctl_type ctl_a;

   always_comb begin
      w_m1 = w_ff - WW'(1);
      h_e  = RW'(h_ff);

      // wrap positions left beyond a narrowed width
      if (WW'(in_col_ff) >= w_ff) begin
         ic_e = '0;
         ir_e = in_row_ff + RW'(1);
      end else begin
         ic_e = WW'(in_col_ff);
         ir_e = in_row_ff;
      end
      if (WW'(out_col_ff) >= w_ff) begin
         oc_e = '0;
         or_e = out_row_ff + RW'(1);
      end else begin
         oc_e = WW'(out_col_ff);
         or_e = out_row_ff;
      end

      ctl_a.pix = '0;
      if (!req_stream.data.flush && ir_e < h_e) begin
         ctl_a.pix.r = req_stream.data.in_red;
         ctl_a.pix.g = req_stream.data.in_green;
         ctl_a.pix.b = req_stream.data.in_blue;
      end
      ctl_a.emit  = (ir_e >= RW'(2)) || (ir_e == RW'(1) && ic_e != '0);
      ctl_a.left  = (oc_e == '0);
      ctl_a.right = (oc_e >= w_m1);
      ctl_a.top   = (or_e == '0);
      ctl_a.bot   = (or_e >= h_e - RW'(1));
      ctl_a.eof   = ctl_a.right && ctl_a.bot;

      ic_n = ic_e + WW'(1);
      if (ic_n >= w_ff) begin
         in_col_in = '0;
         in_row_in = ir_e + RW'(1);
      end else begin
         in_col_in = ic_n[CW-1:0];
         in_row_in = ir_e;
      end

      oc_n = oc_e + WW'(1);
      out_col_in = oc_e[CW-1:0];
      out_row_in = or_e;
      if (ctl_a.emit) begin
         if (ctl_a.eof) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (oc_n >= w_ff) begin
            out_col_in = '0;
            out_row_in = or_e + RW'(1);
         end else begin
            out_col_in = oc_n[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------- window stage ----------------
   bb3_pkg::stage_ctl_type b_ctl_ff;
   logic [CW-1:0]          b_addr_ff;
   bb3_pkg::col_sum_type   col_sum [3];

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff  <= ctl_a;
         b_addr_ff <= ic_e[CW-1:0];
      end
   end

   bb3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ic_e[CW-1:0]),
      .step    (step_b),
      .wr_addr (b_addr_ff),
      .ctl     (b_ctl_ff),
      .col_sum (col_sum)
   );

   // ---------------- column sum stage ----------------
   bb3_pkg::col_sum_type c_col_ff [3];
   logic                 c_left_ff, c_right_ff, c_eof_ff;

   always_ff @(posedge clock) begin
      if (rdy_c && vb_ff) begin
         c_col_ff   <= col_sum;
         c_left_ff  <= b_ctl_ff.left;
         c_right_ff <= b_ctl_ff.right;
         c_eof_ff   <= b_ctl_ff.eof;
      end
   end

   // ---------------- window sum stage ----------------
   bb3_pkg::win_sum_type d_sum_in, d_sum_ff;
   logic                 d_eof_ff;

   always_comb begin
      d_sum_in.r = (c_left_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[0].r))
                 + bb3_pkg::SUM_W'(c_col_ff[1].r)
                 + (c_right_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[2].r));
      d_sum_in.g = (c_left_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[0].g))
                 + bb3_pkg::SUM_W'(c_col_ff[1].g)
                 + (c_right_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[2].g));
      d_sum_in.b = (c_left_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[0].b))
                 + bb3_pkg::SUM_W'(c_col_ff[1].b)
                 + (c_right_ff ? '0 : bb3_pkg::SUM_W'(c_col_ff[2].b));
   end

   always_ff @(posedge clock) begin
      if (rdy_d && vc_ff) begin
         d_sum_ff <= d_sum_in;
         d_eof_ff <= c_eof_ff;
      end
   end

   // ---------------- divide by nine, output register ----------------
   logic [PW-1:0]    prod_r, prod_g, prod_b;
   bb3_pkg::rsp_type out_in, out_ff;

   always_comb begin
      prod_r = PW'(d_sum_ff.r) * PW'(DIV9);
      prod_g = PW'(d_sum_ff.g) * PW'(DIV9);
      prod_b = PW'(d_sum_ff.b) * PW'(DIV9);
      out_in.out_red      = prod_r[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
      out_in.out_green    = prod_g[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
      out_in.out_blue     = prod_b[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
      out_in.out_alpha    = bb3_pkg::ALPHA_OPAQUE;
      out_in.end_of_frame = d_eof_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy_o && vd_ff) begin
         out_ff <= out_in;
      end
   end

   // stage valid flags; items that emit nothing drop after the window stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (rdy_b) vb_ff <= accept;
         if (rdy_c) vc_ff <= vb_ff && b_ctl_ff.emit;
         if (rdy_d) vd_ff <= vc_ff;
         if (rdy_o) ov_ff <= vd_ff;
      end
   end

   assign rsp_stream.valid = ov_ff;
   assign rsp_stream.data  = out_ff;

endmodule

// ===== hw/rtl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the blur core, attached by bind.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_core_defines.svh"

module bb3_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bb3_pkg::rsp_type rsp_data
);

   // no beat may leave right after reset
   `BB3_ASSERT_NR(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid)

   // every result beat is opaque
   `BB3_ASSERT(a_alpha_opaque, clock, reset, rsp_valid |-> rsp_data.out_alpha == bb3_pkg::ALPHA_OPAQUE)

   // input is ready whenever the output register is free or drains
   `BB3_ASSERT(a_ready_when_out_free, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready)

   // a stalled result beat holds
   `BB3_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_stream.ready),
   .rsp_valid (rsp_stream.valid),
   .rsp_ready (rsp_stream.ready),
   .rsp_data  (rsp_stream.data)
);

// ===== tb/bb3_blur_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bb3_blur_checker
// Watches the pixel, result and register ports of the blur core. Keeps its own
// line buffers, 3x3 window and raster counters, works out the blurred pixel
// each accepted beat should produce, if any, and compares every accepted result beat
// against the oldest pending one.
// ----------------------------------------------------------------------------
module bb3_blur_checker
   import bb3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]    csr_wdata,
   output int                  fail_count,
   output int                  outstanding,
   output logic                at_frame_start
);

   localparam int MAX_W = MAX_WIDTH_DEF;
   localparam int MAX_H = MAX_HEIGHT_DEF;

   logic [REG_W-1:0] width_reg;
   logic [REG_W-1:0] height_reg;
   pixel_type        older_line [MAX_W];
   pixel_type        recent_line [MAX_W];
   pixel_type        win [3][3];            // [column: 0 oldest][row: 0 top]
   int unsigned      in_col;
   int unsigned      in_row;
   int unsigned      out_col;
   int unsigned      out_row;
   rsp_type          blurred_q [$];
   int               errs = 0;

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo,
                                           int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic blur_beat(input req_type beat);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned sr;
      int unsigned sg;
      int unsigned sb;
      pixel_type   pix;
      pixel_type   p;
      logic        emit;
      logic        eof;
      rsp_type     res;
      w = clamp_u(width_reg, MIN_WIDTH, MAX_W);
      h = clamp_u(height_reg, MIN_HEIGHT, MAX_H);
      // a shrink between beats wraps the counters into the next row
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      pix = '0;
      if (!beat.flush && in_row < h) begin
         pix.r = beat.in_red;
         pix.g = beat.in_green;
         pix.b = beat.in_blue;
      end
      c = in_col;
      for (int i = 0; i < 3; i++) begin
         win[0][i] = win[1][i];
         win[1][i] = win[2][i];
      end
      win[2][0] = older_line[c];
      win[2][1] = recent_line[c];
      win[2][2] = pix;
      older_line[c]  = recent_line[c];
      recent_line[c] = pix;
      emit = (in_row >= 2) || (in_row == 1 && c >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;

      sr = 0;
      sg = 0;
      sb = 0;
      for (int j = 0; j < 3; j++) begin
         if (j == 0 && out_col == 0) continue;
         if (j == 2 && out_col >= w - 1) continue;
         for (int i = 0; i < 3; i++) begin
            if (i == 0 && out_row == 0) continue;
            if (i == 2 && out_row >= h - 1) continue;
            p = win[j][i];
            sr += p.r;
            sg += p.g;
            sb += p.b;
         end
      end
      eof = (out_col >= w - 1) && (out_row >= h - 1);
      res.out_red      = CH_W'(sr / 9);
      res.out_green    = CH_W'(sg / 9);
      res.out_blue     = CH_W'(sb / 9);
      res.out_alpha    = ALPHA_OPAQUE;
      res.end_of_frame = eof;
      blurred_q.push_back(res);
      if (eof) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_reg  = REG_W'(FRAME_WIDTH_RST);
         height_reg = REG_W'(FRAME_HEIGHT_RST);
         for (int k = 0; k < MAX_W; k++) begin
            older_line[k]  = '0;
            recent_line[k] = '0;
         end
         for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
               win[j][i] = '0;
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
         blurred_q.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_FRAME_WIDTH:  width_reg = csr_wdata;
               REG_FRAME_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            blur_beat(req_data);
         if (rsp_valid && rsp_ready) begin
            if (blurred_q.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("[%0t] result beat with nothing pending: r=%02h g=%02h b=%02h a=%02h eof=%0b",
                           $time, rsp_data.out_red, rsp_data.out_green,
                           rsp_data.out_blue, rsp_data.out_alpha,
                           rsp_data.end_of_frame);
            end else begin
               want = blurred_q.pop_front();
               if (rsp_data.out_red !== want.out_red ||
                   rsp_data.out_green !== want.out_green ||
                   rsp_data.out_blue !== want.out_blue ||
                   rsp_data.out_alpha !== want.out_alpha ||
                   rsp_data.end_of_frame !== want.end_of_frame) begin
                  errs++;
                  if (errs <= 10)
                     $display("[%0t] blur mismatch: exp r=%02h g=%02h b=%02h a=%02h eof=%0b, got r=%02h g=%02h b=%02h a=%02h eof=%0b",
                              $time, want.out_red, want.out_green, want.out_blue,
                              want.out_alpha, want.end_of_frame,
                              rsp_data.out_red, rsp_data.out_green,
                              rsp_data.out_blue, rsp_data.out_alpha,
                              rsp_data.end_of_frame);
               end
            end
         end
      end
      fail_count     <= errs;
      outstanding    <= blurred_q.size();
      at_frame_start <= (in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0);
   end

endmodule

// ===== tb/tb_box_blur_3x3_rgb_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_core
// Drives raster frames into the blur core: a few hand-built tiny frames,
// frames resized midway, frames started at saturated sizes and cut short,
// then random small frames with stray flush and pixel beats. Both stream
// sides stall at random; the checker beside the core judges every result beat.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_core;
   import bb3_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_BEATS = 600;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;
   int               fail_count;
   int               outstanding;
   logic             at_frame_start;
   int               cycle_count = 0;
   int               random_beats = 0;
   logic             burst = 1'b0;
   int               stall_left = 0;
   int               calm_left = 0;
   logic             rsp_calm = 1'b0;

   bb3_stream_if #(.payload_type(req_type)) req_if ();
   bb3_stream_if #(.payload_type(rsp_type)) rsp_if ();

   box_blur_3x3_rgb_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bb3_blur_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_data       (req_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_data       (rsp_if.data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .at_frame_start (at_frame_start)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_size(int raw, int lo, int hi);
      if (raw < lo) return lo;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      int        r;
      r = $urandom_range(0, 9);
      if (r == 0) p = '1;
      else if (r == 1) p = '0;
      else p = pixel_type'(24'($urandom()));
      return p;
   endfunction

   // result side: random backpressure, with calm stretches
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm_left <= $urandom_range(50, 400);
         rsp_calm  <= ($urandom_range(0, 3) == 0);
      end else begin
         calm_left <= calm_left - 1;
      end
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 20)
            stall_left <= pause_len();
      end
   end

   task automatic send_beat(input req_type beat);
      int gap;
      gap = 0;
      if (!burst && $urandom_range(0, 99) >= 70) gap = pause_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= beat;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // width then height on back-to-back edges; write enable stays high between
   task automatic set_size(input int w_raw, input int h_raw);
      csr_we    <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= REG_W'(w_raw);
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= REG_W'(h_raw);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // hold until every pending result is out, then let the pipeline empty
   task automatic wait_idle();
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one frame of w*h pixel slots and w+1 trailing slots, mostly flush, cut after keep beats
   task automatic send_frame(input int w, input int h, input int keep);
      int        slots;
      int        k;
      req_type   beat;
      pixel_type p;
      slots = w * h + w + 1;
      for (k = 0; k < keep && k < slots; k++) begin
         p = rand_pixel();
         beat.in_red   = p.r;
         beat.in_green = p.g;
         beat.in_blue  = p.b;
         if (k < w * h) beat.flush = ($urandom_range(0, 19) == 0);
         else beat.flush = ($urandom_range(0, 9) < 7);
         send_beat(beat);
         random_beats++;
      end
      req_if.valid <= 1'b0;
   endtask

   // finish a resized frame one beat at a time, watching the predicted position
   task automatic close_frame();
      req_type   beat;
      pixel_type p;
      while (!at_frame_start) begin
         p = rand_pixel();
         beat.in_red   = p.r;
         beat.in_green = p.g;
         beat.in_blue  = p.b;
         beat.flush    = 1'($urandom_range(0, 1));
         send_beat(beat);
         random_beats++;
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   initial begin
      req_type beat;
      int      k;
      int      w_raw;
      int      h_raw;
      int      w;
      int      h;
      int      slots;
      int      r;

      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_we       <= 1'b0;
      csr_index    <= REG_FRAME_WIDTH;
      csr_wdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tiny 3x2 frame from saturated sizes, stray flush and stray pixel beats
      burst = 1'b1;
      set_size(0, 0);
      for (k = 0; k < 10; k++) begin
         beat.in_red   = k[0] ? 8'hFF : 8'h00;
         beat.in_green = k[1] ? 8'hAA : 8'h55;
         beat.in_blue  = (k % 3 == 0) ? 8'hFF : 8'h00;
         beat.flush    = (k == 4) || (k >= 6 && k != 7);
         send_beat(beat);
      end
      req_if.valid <= 1'b0;
      wait_idle();

      // all-white 3x3: center sum hits the top of the range
      burst = 1'b0;
      set_size(3, 3);
      for (k = 0; k < 13; k++) begin
         beat.in_red   = 8'hFF;
         beat.in_green = 8'hFF;
         beat.in_blue  = 8'hFF;
         beat.flush    = (k >= 9);
         send_beat(beat);
      end
      req_if.valid <= 1'b0;
      wait_idle();

      // shrink midway
      set_size(8, 4);
      send_frame(8, 4, 21);
      wait_idle();
      set_size(5, 4);
      close_frame();
      wait_idle();

      // grow midway
      set_size(6, 3);
      send_frame(6, 3, 10);
      wait_idle();
      set_size(12, 5);
      close_frame();
      wait_idle();

      // saturated width, cut short by a narrow size
      burst = 1'b1;
      set_size(2047, 2);
      send_frame(1024, 2, 40);
      wait_idle();
      burst = 1'b0;
      set_size(3, 2);
      close_frame();
      wait_idle();

      // saturated height, cut short by a short size
      set_size(2, 2047);
      send_frame(3, 1024, 30);
      wait_idle();
      set_size(3, 2);
      close_frame();
      wait_idle();

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         burst = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 10) w_raw = $urandom_range(0, 2);
         else if (r < 75) w_raw = $urandom_range(3, 12);
         else w_raw = $urandom_range(13, 40);
         r = $urandom_range(0, 99);
         if (r < 10) h_raw = $urandom_range(0, 1);
         else if (r < 80) h_raw = $urandom_range(2, 6);
         else h_raw = $urandom_range(7, 12);
         w = clamp_size(w_raw, MIN_WIDTH, MAX_WIDTH_DEF);
         h = clamp_size(h_raw, MIN_HEIGHT, MAX_HEIGHT_DEF);
         slots = w * h + w + 1;
         set_size(w_raw, h_raw);
         if (!at_frame_start) close_frame();
         else if ($urandom_range(0, 99) < 15) send_frame(w, h, $urandom_range(1, slots - 1));
         else send_frame(w, h, slots);
         wait_idle();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
